[sv/sprite_sheet_frame_sequencer_defines.svh]
// ----------------------------------------------------------------------------
// Sprite sheet frame sequencer assertion macros
// Shared concurrent assertion forms for the sequencer modules.
// ----------------------------------------------------------------------------
`ifndef SPRITE_SHEET_FRAME_SEQUENCER_DEFINES_SVH
`define SPRITE_SHEET_FRAME_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSFS_ASSERT_NOW(name, clk, rstn, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SSFS_ASSERT_NEXT(name, clk, rstn, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error(msg);

`endif

[sv/ssfs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite sheet frame sequencer package
// Field widths, action and register codes, and controller interface types.
// ----------------------------------------------------------------------------
package ssfs_pkg;

  localparam int ACT_W    = 3;
  localparam int FRAME_W  = 10;
  localparam int ID_W     = 4;
  localparam int END_W    = 11;
  localparam int COLS_W   = 11;
  localparam int TICK_W   = 16;
  localparam int CELL_W   = 12;
  localparam int OFFS_W   = 22;
  localparam int CFG_A_W  = 2;
  localparam int CFG_D_W  = 16;
  localparam int TBL_DEPTH = 2 ** ID_W;

  localparam int IN_DATA_W  = 40;  // 38 bits of fields, padded to 5 bytes
  localparam int OUT_DATA_W = 80;  // 75 bits of fields, padded to 10 bytes

  // Divider steps: one quotient bit per cycle.
  localparam int STEP_W = $clog2(FRAME_W + 1);

  localparam int DEF_NUM_ANIMATIONS = 16;
  localparam int DEF_MAX_FRAMES     = 1024;

  localparam logic [ACT_W-1:0] ACT_FWD    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_BWD    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SET    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DEFINE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SELECT = 3'd4;
  localparam logic [ACT_W-1:0] ACT_REARM  = 3'd5;

  localparam logic [CFG_A_W-1:0] CFG_COLS   = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_TICKS  = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_CELL_W = 2'd2;
  localparam logic [CFG_A_W-1:0] CFG_CELL_H = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the input beat
    logic exec;      // apply the action and seed the divider
    logic div_step;  // one restoring divide step
    logic mul;       // register both offset products
    logic out_load;  // move the result into the output register
  } ssfs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
  } ssfs_sts_t;

endpackage

[sv/sprite_sheet_frame_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite sheet frame sequencer
// Steps an animation frame through a selectable range and reports its sheet
// cell offset together with the addressed animation table entry.
// ----------------------------------------------------------------------------
// Each beat passes through the capture, execute, divide, multiply and output
// states; no new beat is taken while one is in flight. A serial divider splits
// the frame into column and row.
// Input is taken again as soon as a result sits in the output register.
// Reset (rst_n low, synchronous) restores default registers, clears the frame,
// the prescaler, the active range and all table entries.
// ----------------------------------------------------------------------------
module sprite_sheet_frame_sequencer #(
  parameter int NUM_ANIMATIONS = ssfs_pkg::DEF_NUM_ANIMATIONS,
  parameter int MAX_FRAMES     = ssfs_pkg::DEF_MAX_FRAMES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input beat, from bit 0: action[2:0], frame_value[12:3], anim_id[16:13],
  // range_begin[26:17], range_end[37:27], zero padding[39:38].
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ssfs_pkg::IN_DATA_W-1:0]  in_tdata,
  // Result beat, from bit 0: frame_index[9:0], offset_x[31:10],
  // offset_y[53:32], entry_begin[63:54], entry_end[74:64], zero padding.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ssfs_pkg::OUT_DATA_W-1:0] out_tdata,
  // Register write port: 0 sheet_columns, 1 ticks_per_frame,
  // 2 cell_width, 3 cell_height.
  input  logic                            cfg_we,
  input  logic [ssfs_pkg::CFG_A_W-1:0]    cfg_addr,
  input  logic [ssfs_pkg::CFG_D_W-1:0]    cfg_wdata
);
  import ssfs_pkg::*;

  // The controller owns the sequence of each beat; the datapath holds all
  // animation state, the table, the divider and the output register.
  ssfs_cmd_t cmd;
  ssfs_sts_t sts;

  ssfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ssfs_dp #(
    .NUM_ANIMATIONS (NUM_ANIMATIONS),
    .MAX_FRAMES     (MAX_FRAMES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[sv/ssfs_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite sheet frame sequencer controller
// Sequences capture, execute, divide, multiply and output for each beat.
// ----------------------------------------------------------------------------
`include "sprite_sheet_frame_sequencer_defines.svh"

module ssfs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  ssfs_pkg::ssfs_sts_t sts,
  output ssfs_pkg::ssfs_cmd_t cmd
);
  import ssfs_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(FRAME_W - 1);

  logic [2:0]        state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  `SSFS_ASSERT_NEXT(a_accept_to_exec, clk, rst_n, in_tvalid && in_tready, state_r == S_EXEC, "accepted beat did not start execution")
  `SSFS_ASSERT_NOW(a_div_count_range, clk, rst_n, state_r == S_DIV, cnt_r <= LAST_STEP, "divide step count out of range")
  `SSFS_ASSERT_NEXT(a_out_to_idle, clk, rst_n, state_r == S_OUT && sts.out_free, state_r == S_IDLE, "result handoff did not return to idle")

endmodule

[sv/ssfs_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite sheet frame sequencer datapath
// Animation state, range table, serial divider, offset multipliers, output.
// ----------------------------------------------------------------------------
`include "sprite_sheet_frame_sequencer_defines.svh"

module ssfs_dp #(
  parameter int NUM_ANIMATIONS = ssfs_pkg::DEF_NUM_ANIMATIONS,
  parameter int MAX_FRAMES     = ssfs_pkg::DEF_MAX_FRAMES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [ssfs_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                             cfg_we,
  input  logic [ssfs_pkg::CFG_A_W-1:0]     cfg_addr,
  input  logic [ssfs_pkg::CFG_D_W-1:0]     cfg_wdata,
  input  ssfs_pkg::ssfs_cmd_t              cmd,
  output ssfs_pkg::ssfs_sts_t              sts,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ssfs_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import ssfs_pkg::*;

  // Configuration registers.
  logic [COLS_W-1:0] cols_r;
  logic [TICK_W-1:0] tpf_r;
  logic [CELL_W-1:0] cell_w_r;
  logic [CELL_W-1:0] cell_h_r;

  // Captured input beat.
  logic [ACT_W-1:0]   act_r;
  logic [FRAME_W-1:0] fval_r;
  logic [ID_W-1:0]    id_r;
  logic [FRAME_W-1:0] rb_r;
  logic [END_W-1:0]   re_r;

  // Animation state.
  logic [TICK_W-1:0]  tick_r, tick_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic [FRAME_W-1:0] act_begin_r, act_begin_nxt;
  logic [END_W-1:0]   act_end_r, act_end_nxt;
  logic [FRAME_W-1:0] tbl_begin_r [TBL_DEPTH];
  logic [END_W-1:0]   tbl_end_r   [TBL_DEPTH];

  // Divider and products.
  logic [COLS_W-1:0]  rem_r, rem_nxt;
  logic [FRAME_W-1:0] quo_r, quo_nxt;
  logic [OFFS_W-1:0]  prod_x_r, prod_y_r;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic               id_ok;
  logic [TICK_W-1:0]  tick_inc;
  logic               tick_due;
  logic [END_W-1:0]   fwd_next;
  logic [FRAME_W-1:0] ent_begin;
  logic [END_W-1:0]   ent_end;
  logic [COLS_W-1:0]  cols_eff;
  logic [COLS_W:0]    div_shift;
  logic               div_fit;

  assign id_ok     = {{(32 - ID_W){1'b0}}, id_r} < 32'(NUM_ANIMATIONS);
  assign ent_begin = id_ok ? tbl_begin_r[id_r] : '0;
  assign ent_end   = id_ok ? tbl_end_r[id_r]   : '0;
  assign cols_eff  = (cols_r == '0) ? COLS_W'(1) : cols_r;

  assign tick_inc = tick_r + 1'b1;
  assign tick_due = (tick_inc == tpf_r);
  assign fwd_next = {1'b0, frame_r} + 1'b1;

  // Action execution.
  always_comb begin
    tick_nxt      = tick_r;
    frame_nxt     = frame_r;
    act_begin_nxt = act_begin_r;
    act_end_nxt   = act_end_r;
    if (cmd.exec) begin
      case (act_r) inside
        ACT_FWD, ACT_BWD: begin
          tick_nxt = tick_due ? '0 : tick_inc;
          if (tick_due) begin
            if (act_r == ACT_FWD) begin
              if (fwd_next >= act_end_r ||
                  {{(32 - END_W){1'b0}}, fwd_next} >= 32'(MAX_FRAMES) ||
                  fwd_next < {1'b0, act_begin_r}) begin
                frame_nxt = act_begin_r;
              end else begin
                frame_nxt = fwd_next[FRAME_W-1:0];
              end
            end else begin
              // Stepping below the range start, or below frame zero, wraps to
              // the last frame of the range.
              if (frame_r == '0 || (frame_r - 1'b1) < act_begin_r) begin
                frame_nxt = (act_end_r == '0) ? '0 : FRAME_W'(act_end_r - 1'b1);
              end else begin
                frame_nxt = frame_r - 1'b1;
              end
            end
          end
        end
        ACT_SET: frame_nxt = fval_r;
        ACT_SELECT: begin
          act_begin_nxt = ent_begin;
          act_end_nxt   = ent_end;
        end
        ACT_REARM: tick_nxt = tpf_r - 1'b1;
        default: ;
      endcase
    end
  end

  // Restoring divide of frame by column count, one quotient bit per step.
  assign div_shift = {rem_r, quo_r[FRAME_W-1]};
  assign div_fit   = div_shift >= {1'b0, cols_eff};

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (cmd.exec) begin
      rem_nxt = '0;
      quo_nxt = frame_nxt;
    end else if (cmd.div_step) begin
      rem_nxt = div_fit ? COLS_W'(div_shift - {1'b0, cols_eff}) : div_shift[COLS_W-1:0];
      quo_nxt = {quo_r[FRAME_W-2:0], div_fit};
    end
  end

  assign sts.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r      <= COLS_W'(1);
      tpf_r       <= TICK_W'(1);
      cell_w_r    <= '0;
      cell_h_r    <= '0;
      tick_r      <= '0;
      frame_r     <= '0;
      act_begin_r <= '0;
      act_end_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < TBL_DEPTH; i++) begin
        tbl_begin_r[i] <= '0;
        tbl_end_r[i]   <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_COLS:   cols_r   <= cfg_wdata[COLS_W-1:0];
          CFG_TICKS:  tpf_r    <= cfg_wdata[TICK_W-1:0];
          CFG_CELL_W: cell_w_r <= cfg_wdata[CELL_W-1:0];
          CFG_CELL_H: cell_h_r <= cfg_wdata[CELL_W-1:0];
          default: ;
        endcase
      end
      tick_r      <= tick_nxt;
      frame_r     <= frame_nxt;
      act_begin_r <= act_begin_nxt;
      act_end_r   <= act_end_nxt;
      if (cmd.exec && act_r == ACT_DEFINE && id_ok) begin
        tbl_begin_r[id_r] <= rb_r;
        tbl_end_r[id_r]   <= re_r;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r  <= in_tdata[2:0];
      fval_r <= in_tdata[12:3];
      id_r   <= in_tdata[16:13];
      rb_r   <= in_tdata[26:17];
      re_r   <= in_tdata[37:27];
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (cmd.mul) begin
      prod_x_r <= rem_r[FRAME_W-1:0] * cell_w_r;
      prod_y_r <= quo_r * cell_h_r;
    end
    if (cmd.out_load) begin
      out_data_r <= {5'd0, ent_end, ent_begin, prod_y_r, prod_x_r, frame_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `SSFS_ASSERT_NOW(a_load_when_free, clk, rst_n, cmd.out_load, !out_valid_r || out_tready, "result loaded over an untaken result")
  `SSFS_ASSERT_NOW(a_rem_below_cols, clk, rst_n, cmd.mul, rem_r < cols_eff, "divider remainder not below column count")
  `SSFS_ASSERT_NOW(a_exec_not_div, clk, rst_n, cmd.exec, !cmd.div_step && !cmd.mul, "execute overlaps divide or multiply")

endmodule
